@@ design/rtt_pkg.sv @@
// shared types and constants for the round-trip time estimator
`timescale 1ns / 1ps
`default_nettype none

package rtt_pkg;

	localparam int unsigned SAMPLE_BITS = 16;
	localparam int unsigned COUNT_BITS  = 32;
	localparam int unsigned QUOT_BITS   = 16;

	localparam logic [SAMPLE_BITS-1:0] KEEP_MIN     = 16'd5;
	localparam logic [SAMPLE_BITS-1:0] VAR_RESET    = 16'd5;
	localparam logic [SAMPLE_BITS-1:0] VAR_FLOOR    = 16'd10;
	localparam logic [SAMPLE_BITS-1:0] SMOOTH_FLOOR = 16'd10;

	localparam logic KIND_NORMAL  = 1'b0;
	localparam logic KIND_CONNECT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_START,
		ST_WAIT,
		ST_EMIT
	} rtt_state_t;

endpackage

`default_nettype wire

@@ design/rtt_div.sv @@
// iterative restoring divider for the running mean, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module rtt_div #(
	parameter int unsigned SUM_BITS = 48
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [SUM_BITS-1:0]                dividend,
	input  wire logic [rtt_pkg::COUNT_BITS-1:0]     divisor,
	output logic                                    done,
	output logic [rtt_pkg::QUOT_BITS-1:0]           quotient
);
	import rtt_pkg::*;

	localparam int unsigned HI_BITS  = SUM_BITS - QUOT_BITS;
	localparam int unsigned CNT_BITS = $clog2(QUOT_BITS);

	logic [HI_BITS-1:0]    hi;
	logic [COUNT_BITS-1:0] rem_q;
	logic [QUOT_BITS-1:0]  low_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  fits;

	assign hi    = dividend[SUM_BITS-1:QUOT_BITS];
	assign trial = {rem_q, low_q[QUOT_BITS-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (divisor == '0 || {{(SUM_BITS){1'b0}}, hi} >=
						{{(SUM_BITS+HI_BITS-COUNT_BITS){1'b0}}, divisor}) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_BITS'(QUOT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			if (divisor == '0) begin
				low_q <= '0;
			end else if ({{(SUM_BITS){1'b0}}, hi} >=
					{{(SUM_BITS+HI_BITS-COUNT_BITS){1'b0}}, divisor}) begin
				low_q <= '1;
			end else begin
				low_q <= dividend[QUOT_BITS-1:0];
			end
			rem_q <= COUNT_BITS'(hi);
		end else if (busy_q) begin
			rem_q <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			low_q <= {low_q[QUOT_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;

endmodule

`default_nettype wire

@@ design/rtt_estimator.sv @@
// top level of the round-trip time estimator with stream ports
`timescale 1ns / 1ps
`default_nettype none

// Jacobson-style round-trip time estimator. Each input item carries one sample
// in milliseconds (tdata) and its kind (tuser): a normal sample is raised to at
// least 5 ms and updates the minimum, the mean deviation, the smoothed estimate
// and the running sum, count and peak; a connect-acknowledge sample loads the
// smoothed estimate directly and updates the minimum only. Every item yields
// exactly one result item with the state after the update and the running mean
// (sum over count, 0 before the first normal sample, 65535 when it would not
// fit). From acceptance, an item passes through the estimator update, the
// divider start, 16 compare-subtract steps of the divider plus its done
// cycle, and the load of the output register. When the count is zero or the
// mean would not fit, the divider finishes right after its start. The block
// takes one item at a time; it is ready again in the cycle after the result
// is loaded, even while that result still waits downstream. A result that
// still waits when the next one is ready holds the block. Count and sum
// saturate rather than wrap.

module rtt_estimator #(
	parameter int unsigned SUM_BITS = 48
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample_ms
	input  wire logic        s_tuser,   // [0] kind
	// result items
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [15:0] smoothed_rtt, [31:16] rtt_variation, [47:32] min_rtt,
	// [63:48] mean_rtt, [79:64] peak_rtt
	output logic [79:0]      m_tdata
);
	import rtt_pkg::*;

	rtt_state_t state_q, state_d;

	// latched input item
	logic                   kind_q;
	logic [SAMPLE_BITS-1:0] sample_q;

	// estimator state
	logic [SAMPLE_BITS-1:0] smooth_q;
	logic [SAMPLE_BITS-1:0] var_q;
	logic [SAMPLE_BITS-1:0] min_q;
	logic [SAMPLE_BITS-1:0] max_q;
	logic [SUM_BITS-1:0]    sum_q;
	logic [COUNT_BITS-1:0]  count_q;

	// output register
	logic        out_valid_q;
	logic [79:0] out_data_q;

	// sequencer outputs
	logic accept;
	logic div_start;
	logic out_load;

	// update datapath
	logic [SAMPLE_BITS-1:0] keep;
	logic [SAMPLE_BITS-1:0] min_cand;
	logic [SAMPLE_BITS-1:0] diff;
	logic [17:0]            var_sum;
	logic [SAMPLE_BITS-1:0] var_new;
	logic [18:0]            smooth_sum;
	logic [SAMPLE_BITS-1:0] smooth_new;
	logic [SUM_BITS:0]      sum_add;

	logic                   div_done;
	logic [QUOT_BITS-1:0]   div_quot;

	// keep is the clamped sample for normal items
	assign keep     = (sample_q > KEEP_MIN) ? sample_q : KEEP_MIN;
	assign min_cand = (kind_q == KIND_CONNECT) ? sample_q : keep;
	assign diff     = (smooth_q > keep) ? (smooth_q - keep) : (keep - smooth_q);

	// (3*var + diff)/4 and (7*smooth + keep)/8, both still fit 16 bits
	assign var_sum    = 18'(var_q) * 18'd3 + 18'(diff);
	assign var_new    = var_sum[17:2];
	assign smooth_sum = 19'(smooth_q) * 19'd7 + 19'(keep);
	assign smooth_new = smooth_sum[18:3];
	assign sum_add    = {1'b0, sum_q} + (SUM_BITS+1)'(keep);

	assign accept = s_tvalid && s_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_START;
			ST_START:  state_d = ST_WAIT;
			ST_WAIT:   if (div_done) state_d = ST_EMIT;
			ST_EMIT:   if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_START:  div_start = 1'b1;
			ST_EMIT:   out_load = !out_valid_q || m_tready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// input item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= s_tuser;
			sample_q <= s_tdata;
		end
	end

	// estimator state update, once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			var_q    <= VAR_RESET;
			min_q    <= '0;
			max_q    <= '0;
			sum_q    <= '0;
			count_q  <= '0;
		end else if (state_q == ST_UPDATE) begin
			// minimum: zero means none seen yet
			if (min_q == '0 || min_cand < min_q) begin
				min_q <= min_cand;
			end
			if (kind_q == KIND_CONNECT) begin
				smooth_q <= sample_q;
			end else begin
				var_q    <= (var_new < VAR_FLOOR) ? VAR_FLOOR : var_new;
				smooth_q <= (smooth_new < SMOOTH_FLOOR) ? SMOOTH_FLOOR : smooth_new;
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
				// saturate the sum on carry out
				sum_q <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
				if (keep > max_q) begin
					max_q <= keep;
				end
			end
		end
	end

	// divider for sum over count
	rtt_div #(
		.SUM_BITS (SUM_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// output register, decouples the result from the next input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {max_q, div_quot, min_q, var_q, smooth_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

`ifndef NO_ASSERTIONS
	// a normal sample always leaves the deviation at or above its floor
	a_var_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && kind_q == KIND_NORMAL) |=> (var_q >= VAR_FLOOR))
		else $error("deviation below floor after normal sample");

	// the divider only finishes while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_WAIT))
		else $error("divider done outside wait state");

	// any counted sample leaves a nonzero peak
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> (max_q >= KEEP_MIN))
		else $error("peak missing with nonzero count");

	// the running sum never falls
	a_sum_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |=> (sum_q >= $past(sum_q)))
		else $error("running sum decreased");

	// no new item while an earlier one is still in the update or divide
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (state_q == ST_IDLE && !div_done))
		else $error("ready while an item is in flight");
`endif

endmodule

`default_nettype wire
